// ----- rtl/u8u16_pkg.sv -----
// Shared types and constants for the UTF-8 to UTF-16BE transcoder.
package u8u16_pkg;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_LEAD  = 3'd1;
    localparam logic [2:0] ERR_BAD_CONT  = 3'd2;
    localparam logic [2:0] ERR_SURROGATE = 3'd3;
    localparam logic [2:0] ERR_RANGE     = 3'd4;

    localparam logic [20:0] CP_MAX      = 21'h10FFFF;
    localparam logic [20:0] CP_BMP_MAX  = 21'h00FFFF;
    localparam logic [20:0] CP_SUPP_OFS = 21'h010000;
    localparam logic [20:0] CP_SUR_LO   = 21'h00D800;
    localparam logic [20:0] CP_SUR_HI   = 21'h00DFFF;
    localparam logic [5:0]  HI_SUR_TAG  = 6'b110110;
    localparam logic [5:0]  LO_SUR_TAG  = 6'b110111;

    typedef struct packed {
        logic [1:0]  pending;
        logic [20:0] accum;
        logic        discarding;
    } dec_state_t;

    // Up to four result beats produced by one input byte; bytes[0] goes first.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
        logic            byte_valid;
        logic            string_done;
        logic [2:0]      error_code;
    } burst_t;

endpackage

// ----- rtl/utf8_to_utf16be_transcoder.sv -----
// UTF-8 to UTF-16BE transcoder: decode state, burst register and beat serialiser.
// Latency: the first result beat is presented the cycle after its input beat is taken.
// Throughput: one result beat per cycle while m_ready is high; an input byte yields 0, 1, 2 or 4
// result beats, so ASCII input, two beats per byte, is limited by the single byte-wide result port.
// A new input beat is taken in the cycle the last result beat of the previous one leaves.
// Reset (aresetn low, synchronous) clears the decode state and empties the burst register.
module utf8_to_utf16be_transcoder
    import u8u16_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_byte_valid,
    output logic       m_string_done,
    output logic [2:0] m_error_code,
    output logic       m_run_last
);

    // Decode state: pending continuation count, partial code point, discard flag.
    dec_state_t state_reg;
    dec_state_t state_next;

    // Burst register holds the result beats of one input byte while they drain.
    burst_t     burst_reg;
    burst_t     burst_next;
    logic       busy_reg;
    logic [1:0] idx_reg;

    logic       s_fire;
    logic       m_fire;
    logic       last_beat;

    u8u16_decode u_decode (
        .data_byte  (s_data_byte),
        .state_cur  (state_reg),
        .state_next (state_next),
        .burst      (burst_next)
    );

    // Last beat of the burst: index one below the beat count.
    assign last_beat = ({1'b0, idx_reg} + 3'd1) == burst_reg.count;

    assign m_valid = busy_reg;
    assign m_fire  = m_valid && m_ready;
    // Take the next byte when empty, or as the final beat of the burst leaves.
    assign s_ready = !busy_reg || (m_ready && last_beat);
    assign s_fire  = s_valid && s_ready;

    assign m_out_byte    = burst_reg.bytes[idx_reg];
    assign m_byte_valid  = burst_reg.byte_valid;
    assign m_string_done = burst_reg.string_done;
    assign m_error_code  = burst_reg.error_code;
    assign m_run_last    = last_beat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
            busy_reg  <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            if (s_fire) begin
                state_reg <= state_next;
            end
            // A new burst takes over as the old one's last beat leaves.
            // Lead bytes, non-final continuation bytes and dropped bytes leave no beats behind.
            if (s_fire && burst_next.count != 3'd0) begin
                busy_reg <= 1'b1;
                idx_reg  <= 2'd0;
            end else if (m_fire) begin
                if (last_beat) begin
                    busy_reg <= 1'b0;
                end else begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
        end
    end

    // Payload only; loaded with each new burst.
    always_ff @(posedge aclk) begin
        if (s_fire && burst_next.count != 3'd0) begin
            burst_reg <= burst_next;
        end
    end

`ifndef SYNTHESIS
    a_busy_has_beats: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (burst_reg.count != 3'd0))
        else $error("burst register busy with no beats");

    a_drain_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && last_beat && !s_fire) |=> !m_valid)
        else $error("result channel still valid after last beat left");

    a_status_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_byte_valid) |-> m_run_last)
        else $error("status beat not alone in its burst");

    a_error_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_error_code != ERR_NONE) |-> !m_byte_valid)
        else $error("error beat carries data");

    a_discard_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.discarding |-> (state_reg.pending == 2'd0))
        else $error("sequence still open while discarding");
`endif

endmodule

// ----- rtl/u8u16_decode.sv -----
// Combinational UTF-8 sequence decoder and UTF-16BE burst builder.
module u8u16_decode
    import u8u16_pkg::*;
(
    input  logic [7:0] data_byte,
    input  dec_state_t state_cur,
    output dec_state_t state_next,
    output burst_t     burst
);

    logic        do_emit;
    logic        do_fail;
    logic [2:0]  fail_code;
    logic [20:0] cp;
    logic [20:0] acc_shift;
    logic [20:0] cp_ofs;
    logic [15:0] hi_sur;
    logic [15:0] lo_sur;

    assign acc_shift = {state_cur.accum[14:0], data_byte[5:0]};
    assign cp_ofs    = cp - CP_SUPP_OFS;
    assign hi_sur    = {HI_SUR_TAG, cp_ofs[19:10]};
    assign lo_sur    = {LO_SUR_TAG, cp_ofs[9:0]};

    always_comb begin
        state_next = state_cur;
        burst      = '0;
        do_emit    = 1'b0;
        do_fail    = 1'b0;
        fail_code  = ERR_NONE;
        cp         = '0;

        if (data_byte == 8'h00) begin
            state_next        = '0;
            burst.count       = 3'd1;
            burst.string_done = 1'b1;
            burst.error_code  = (!state_cur.discarding && state_cur.pending != 2'd0)
                                ? ERR_BAD_CONT : ERR_NONE;
        end else if (state_cur.discarding) begin
            state_next = state_cur;
        end else if (state_cur.pending == 2'd0) begin
            if (data_byte[7] == 1'b0) begin
                do_emit = 1'b1;
                cp      = {13'd0, data_byte};
            end else if (data_byte[7:5] == 3'b110) begin
                state_next.accum   = {16'd0, data_byte[4:0]};
                state_next.pending = 2'd1;
            end else if (data_byte[7:4] == 4'b1110) begin
                state_next.accum   = {17'd0, data_byte[3:0]};
                state_next.pending = 2'd2;
            end else if (data_byte[7:3] == 5'b11110) begin
                state_next.accum   = {18'd0, data_byte[2:0]};
                state_next.pending = 2'd3;
            end else begin
                do_fail   = 1'b1;
                fail_code = ERR_BAD_LEAD;
            end
        end else begin
            if (data_byte[7:6] != 2'b10) begin
                do_fail   = 1'b1;
                fail_code = ERR_BAD_CONT;
            end else if (state_cur.pending == 2'd1) begin
                do_emit            = 1'b1;
                cp                 = acc_shift;
                state_next.accum   = '0;
                state_next.pending = 2'd0;
            end else begin
                state_next.accum   = acc_shift;
                state_next.pending = state_cur.pending - 2'd1;
            end
        end

        if (do_emit) begin
            if (cp <= CP_BMP_MAX) begin
                if (cp >= CP_SUR_LO && cp <= CP_SUR_HI) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_SURROGATE;
                end else begin
                    burst.count      = 3'd2;
                    burst.byte_valid = 1'b1;
                    burst.bytes[0]   = cp[15:8];
                    burst.bytes[1]   = cp[7:0];
                end
            end else if (cp > CP_MAX) begin
                do_fail   = 1'b1;
                fail_code = ERR_RANGE;
            end else begin
                burst.count      = 3'd4;
                burst.byte_valid = 1'b1;
                burst.bytes[0]   = hi_sur[15:8];
                burst.bytes[1]   = hi_sur[7:0];
                burst.bytes[2]   = lo_sur[15:8];
                burst.bytes[3]   = lo_sur[7:0];
            end
        end

        if (do_fail) begin
            state_next            = '0;
            state_next.discarding = 1'b1;
            burst                 = '0;
            burst.count           = 3'd1;
            burst.error_code      = fail_code;
        end
    end

endmodule

// ----- sim/tb_utf8_to_utf16be_transcoder.sv -----
// Self-checking testbench for the UTF-8 to UTF-16BE transcoder.
module tb_utf8_to_utf16be_transcoder
    import u8u16_pkg::*;
();

    // Clock, reset and the run limit.
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int SETTLE_CYCLES  = 8;    // quiet cycles after the last expected beat
    localparam int HOLD_CYCLES    = 300;  // long sink hold-off for the back-pressure check

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;

    // Input channel: one UTF-8 byte per beat.
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte = 8'h00;

    // Result channel: one UTF-16BE byte, error or end-of-string marker per beat.
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_byte_valid;
    logic       m_string_done;
    logic [2:0] m_error_code;
    logic       m_run_last;

    // One result beat as the block should present it.
    typedef struct {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       string_done;
        logic [2:0] error_code;
        logic       run_last;
    } u16_beat_t;

    // Scoreboard: its own copy of the decoder state turns each accepted UTF-8 byte into
    // the result beats it must cause; beats from the block are then matched in order.
    class utf16_scoreboard;
        u16_beat_t   utf16_expected[$];
        logic [1:0]  cont_left;
        logic [20:0] code_acc;
        logic        dropping;
        int          mismatches;

        function new();
            cont_left  = '0;
            code_acc   = '0;
            dropping   = 1'b0;
            mismatches = 0;
        endfunction

        function int outstanding();
            return utf16_expected.size();
        endfunction

        task report(string what);
            $display("[%0t] MISMATCH: %s", $time, what);
            mismatches++;
        endtask

        function void push_beat(logic [7:0] ob, logic bv, logic sd, logic [2:0] ec, logic rl);
            u16_beat_t b;
            b.out_byte    = ob;
            b.byte_valid  = bv;
            b.string_done = sd;
            b.error_code  = ec;
            b.run_last    = rl;
            utf16_expected.push_back(b);
        endfunction

        // Any error: one error beat, then drop everything up to the terminator.
        function void flag_error(logic [2:0] ec);
            dropping  = 1'b1;
            cont_left = '0;
            code_acc  = '0;
            push_beat(8'h00, 1'b0, 1'b0, ec, 1'b1);
        endfunction

        // Completed code point: two bytes in the BMP, a surrogate pair above it.
        function void emit_utf16(logic [20:0] cp);
            logic [20:0] ofs;
            logic [15:0] hi_unit;
            logic [15:0] lo_unit;
            if (cp <= CP_BMP_MAX) begin
                if (cp >= CP_SUR_LO && cp <= CP_SUR_HI) begin
                    flag_error(ERR_SURROGATE);
                end else begin
                    push_beat(cp[15:8], 1'b1, 1'b0, ERR_NONE, 1'b0);
                    push_beat(cp[7:0],  1'b1, 1'b0, ERR_NONE, 1'b1);
                end
            end else if (cp > CP_MAX) begin
                flag_error(ERR_RANGE);
            end else begin
                ofs     = cp - CP_SUPP_OFS;
                hi_unit = {HI_SUR_TAG, ofs[19:10]};
                lo_unit = {LO_SUR_TAG, ofs[9:0]};
                push_beat(hi_unit[15:8], 1'b1, 1'b0, ERR_NONE, 1'b0);
                push_beat(hi_unit[7:0],  1'b1, 1'b0, ERR_NONE, 1'b0);
                push_beat(lo_unit[15:8], 1'b1, 1'b0, ERR_NONE, 1'b0);
                push_beat(lo_unit[7:0],  1'b1, 1'b0, ERR_NONE, 1'b1);
            end
        endfunction

        // Called for every UTF-8 byte the block accepts.
        function void take_utf8_byte(logic [7:0] b);
            logic [2:0]  ec;
            logic [20:0] cp;
            if (b == 8'h00) begin
                // terminator: a sequence still open counts as truncated, unless already failed
                ec        = (!dropping && cont_left != 0) ? ERR_BAD_CONT : ERR_NONE;
                cont_left = '0;
                code_acc  = '0;
                dropping  = 1'b0;
                push_beat(8'h00, 1'b0, 1'b1, ec, 1'b1);
            end else if (!dropping) begin
                if (cont_left == 0) begin
                    if (!b[7]) begin
                        emit_utf16({13'd0, b});
                    end else if (b[7:5] == 3'b110) begin
                        code_acc  = {16'd0, b[4:0]};
                        cont_left = 2'd1;
                    end else if (b[7:4] == 4'b1110) begin
                        code_acc  = {17'd0, b[3:0]};
                        cont_left = 2'd2;
                    end else if (b[7:3] == 5'b11110) begin
                        code_acc  = {18'd0, b[2:0]};
                        cont_left = 2'd3;
                    end else begin
                        flag_error(ERR_BAD_LEAD);
                    end
                end else if (b[7:6] != 2'b10) begin
                    flag_error(ERR_BAD_CONT);
                end else begin
                    code_acc  = {code_acc[14:0], b[5:0]};
                    cont_left = cont_left - 2'd1;
                    if (cont_left == 0) begin
                        cp       = code_acc;
                        code_acc = '0;
                        emit_utf16(cp);
                    end
                end
            end
        endfunction

        // Called for every result beat the testbench accepts.
        task check_beat(u16_beat_t got);
            u16_beat_t want;
            if (utf16_expected.size() == 0) begin
                report($sformatf("beat with nothing expected: byte %02h valid %b done %b err %0d",
                                 got.out_byte, got.byte_valid, got.string_done, got.error_code));
                return;
            end
            want = utf16_expected.pop_front();
            if (got.out_byte !== want.out_byte)
                report($sformatf("out_byte %02h, expected %02h", got.out_byte, want.out_byte));
            if (got.byte_valid !== want.byte_valid)
                report($sformatf("byte_valid %b, expected %b", got.byte_valid, want.byte_valid));
            if (got.string_done !== want.string_done)
                report($sformatf("string_done %b, expected %b",
                                 got.string_done, want.string_done));
            if (got.error_code !== want.error_code)
                report($sformatf("error_code %0d, expected %0d",
                                 got.error_code, want.error_code));
            if (got.run_last !== want.run_last)
                report($sformatf("run_last %b, expected %b", got.run_last, want.run_last));
        endtask
    endclass

    utf16_scoreboard sb = new();

    // Traffic shaping, changed only between phases.
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int          items_sent     = 0;

    // Sink hold-off: the stimulus bumps hold_req; the sink process counts the cycles.
    int unsigned hold_req       = 0;
    int unsigned hold_ack       = 0;
    int unsigned sink_hold_left = 0;

    // String under construction, terminator not included.
    logic [7:0] str_bytes[$];

    // Hand-picked corner strings: ASCII, the 2-byte minimum and the 3/4-byte maxima, a bad lead
    // followed by a byte that must be dropped, a bad continuation, a surrogate, a code point
    // above U+10FFFF and a sequence cut short by the terminator.
    logic [7:0] corner_bytes [0:28] = '{
        8'h41, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h00,
        8'h80, 8'h7F, 8'h00,
        8'hE0, 8'h41, 8'h00,
        8'hED, 8'hA0, 8'h80, 8'h00,
        8'hF4, 8'h90, 8'h80, 8'h80, 8'h00,
        8'hF0, 8'h90, 8'h00
    };

    utf8_to_utf16be_transcoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_byte_valid  (m_byte_valid),
        .m_string_done (m_string_done),
        .m_error_code  (m_error_code),
        .m_run_last    (m_run_last)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Sink: random stalls, or a long hold-off when one has been requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack       <= hold_req;
            sink_hold_left <= HOLD_CYCLES;
            m_ready        <= 1'b0;
        end else if (sink_hold_left != 0) begin
            sink_hold_left <= sink_hold_left - 1;
            m_ready        <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Result monitor: values seen here are those from before the edge, so no race.
    always @(posedge aclk) begin
        u16_beat_t got;
        if (aresetn && m_valid && m_ready) begin
            got.out_byte    = m_out_byte;
            got.byte_valid  = m_byte_valid;
            got.string_done = m_string_done;
            got.error_code  = m_error_code;
            got.run_last    = m_run_last;
            sb.check_beat(got);
        end
    end

    // Drive one byte, idling first at random; returns at the edge that takes the beat.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        sb.take_utf8_byte(b);
        items_sent++;
    endtask

    task automatic send_string();
        foreach (str_bytes[i])
            send_byte(str_bytes[i]);
        send_byte(8'h00);
    endtask

    // Stop offering beats and wait for every expected result, then a few quiet cycles.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Append one encoded sequence; the lead byte carries the top bits of cp as given,
    // so short values in long forms come out overlong.
    function automatic void put_seq(logic [20:0] cp, int n);
        case (n)
            1: begin
                str_bytes.push_back({1'b0, cp[6:0]});
            end
            2: begin
                str_bytes.push_back({3'b110, cp[10:6]});
                str_bytes.push_back({2'b10, cp[5:0]});
            end
            3: begin
                str_bytes.push_back({4'b1110, cp[15:12]});
                str_bytes.push_back({2'b10, cp[11:6]});
                str_bytes.push_back({2'b10, cp[5:0]});
            end
            default: begin
                str_bytes.push_back({5'b11110, cp[20:18]});
                str_bytes.push_back({2'b10, cp[17:12]});
                str_bytes.push_back({2'b10, cp[11:6]});
                str_bytes.push_back({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    // Mostly well-formed strings of random code points; now and then a stray byte or a
    // sequence cut short. Surrogates fall in the 3-byte range; out-of-range values come from rare wide 4-byte draws.
    function automatic void build_random_string();
        int          n_chars;
        int          kind;
        int          n_len;
        logic [20:0] cp;
        str_bytes.delete();
        n_chars = $urandom_range(8);
        for (int i = 0; i < n_chars; i++) begin
            kind = $urandom_range(99);
            if (kind < 35) begin
                cp = 21'($urandom_range(127, 1));
                put_seq(cp, 1);
            end else if (kind < 55) begin
                cp = 21'($urandom_range(16'h07FF));
                put_seq(cp, 2);
            end else if (kind < 75) begin
                cp = 21'($urandom_range(16'hFFFF));
                put_seq(cp, 3);
            end else if (kind < 94) begin
                if ($urandom_range(7) == 0)
                    cp = 21'($urandom_range(21'h1FFFFF));
                else
                    cp = 21'($urandom_range(21'h10FFFF));
                put_seq(cp, 4);
            end else if (kind < 97) begin
                str_bytes.push_back(8'($urandom_range(255, 1)));
            end else begin
                n_len = $urandom_range(4, 2);
                cp    = 21'($urandom_range(21'h10FFFF));
                put_seq(cp, n_len);
                repeat ($urandom_range(n_len - 1, 1))
                    void'(str_bytes.pop_back());
            end
        end
    endfunction

    task automatic run_random_phase(int unsigned src_pct, int unsigned sink_pct, int n_items);
        int start;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        start          = items_sent;
        while (items_sent - start < n_items) begin
            build_random_string();
            send_string();
        end
        wait_drained();
    endtask

    // Stimulus.
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Corner strings, no idling on either side.
        foreach (corner_bytes[i])
            send_byte(corner_bytes[i]);
        wait_drained();

        // Random strings: free-running, then a sparse sender, a stalling sink, then both.
        run_random_phase(0, 0, 100);
        run_random_phase(85, 0, 100);
        run_random_phase(0, 85, 100);
        run_random_phase(16, 16, 100);

        // Back-pressure: the sink holds off while ASCII keeps coming, so the burst register
        // fills and s_ready must drop until the sink lets go.
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_req      <= hold_req + 1;
        str_bytes.delete();
        repeat (60) str_bytes.push_back(8'($urandom_range(127, 1)));
        send_string();
        wait_drained();

        if (sb.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Run limit: generous over the slowest legal run.
    initial begin
        #(TIMEOUT_CYCLES * 12);
        $display("TIMEOUT after %0d cycles, %0d beats still expected",
                 TIMEOUT_CYCLES, sb.outstanding());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/u8u16_pkg.sv
rtl/u8u16_decode.sv
rtl/utf8_to_utf16be_transcoder.sv
sim/tb_utf8_to_utf16be_transcoder.sv
